### rtl/hpsd_pkg.sv
// Package for the heading PID block with settle detection.
// Field widths, fixed-point constants and register indexes; no dependencies.
`default_nettype none

package hpsd_pkg;

	localparam int ANGLE_W = 15;
	localparam int GAIN_W  = 16;
	localparam int BAND_W  = 14;
	localparam int ERR_W   = 24;
	localparam int SUM_W   = 40;
	localparam int CNT_W   = 16;
	localparam int DRIVE_W = 24;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int SETTLE_FRAMES = 10;

	// angles in 1/64 degree
	localparam int HALF_TURN = 11520;
	localparam int FULL_TURN = 23040;

	// quotient bits produced by the divider, one per cycle
	localparam int DIV_STEPS = 24;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_WEIGHT_PREV = 3'd0;
	localparam cfg_idx_t CFG_WEIGHT_CUR  = 3'd1;
	localparam cfg_idx_t CFG_GAIN_P      = 3'd2;
	localparam cfg_idx_t CFG_GAIN_I      = 3'd3;
	localparam cfg_idx_t CFG_GAIN_D      = 3'd4;
	localparam cfg_idx_t CFG_SETTLE_BAND = 3'd5;
	localparam cfg_idx_t CFG_TURN_DIV    = 3'd6;

endpackage

`default_nettype wire

### rtl/heading_pid_with_settle_detect.sv
// Heading PID controller with filtered error and settle detection.
// Uses hpsd_pkg for widths, constants and register indexes.
//
// Usage: one item per sensor frame on the input channel (in_valid/in_stall) carries
// the measured heading, the target heading and a restart flag; restart clears the
// filter, integral, derivative history and settle counter before the item is used.
// Each item gives exactly one result on the output channel (out_valid/out_stall):
// turn_drive, the negated PID sum over turn_divisor with 8 fraction bits, and the
// settled flag.
// After acceptance, a single 17x25 multiplier and the accumulator work through the filter
// and PID products, then a one-bit-per-cycle divider runs, then the output is loaded.
// in_stall stays high while an item is in work, so no new item is taken until the
// last one is through. The result sits in an output register; the next item is
// accepted while it waits. If the receiver stalls past the end of the next item,
// that item waits in its final state until the register frees.
// Reset clears the state and loads the default registers. Registers are to be written
// over cfg_we/cfg_index/cfg_data only while the block is idle; the block itself does
// not enforce this. Unknown indexes are ignored.
`default_nettype none

module heading_pid_with_settle_detect (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire hpsd_pkg::cfg_idx_t               cfg_index,
	input  wire logic [hpsd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [hpsd_pkg::ANGLE_W-1:0]     heading_now,
	input  wire logic [hpsd_pkg::ANGLE_W-1:0]     heading_goal,
	input  wire logic                             restart,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [hpsd_pkg::DRIVE_W-1:0]   turn_drive,
	output logic                                  settled
);
	import hpsd_pkg::*;

	localparam int ACC_W  = 58;
	localparam int MA_W   = 17;
	localparam int MB_W   = 25;
	localparam int PROD_W = MA_W + MB_W;
	localparam int DVD_W  = 60;
	localparam int STEP_W = $clog2(DIV_STEPS);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_W0   = 4'd1;
	localparam logic [3:0] S_W1   = 4'd2;
	localparam logic [3:0] S_W2   = 4'd3;
	localparam logic [3:0] S_F    = 4'd4;
	localparam logic [3:0] S_SUM  = 4'd5;
	localparam logic [3:0] S_PD   = 4'd6;
	localparam logic [3:0] S_IL   = 4'd7;
	localparam logic [3:0] S_IH   = 4'd8;
	localparam logic [3:0] S_AH   = 4'd9;
	localparam logic [3:0] S_DIV0 = 4'd10;
	localparam logic [3:0] S_DIV  = 4'd11;
	localparam logic [3:0] S_FIN  = 4'd12;

	localparam logic signed [ACC_W-1:0] ROUND_15 = ACC_W'(16384);
	localparam logic signed [ACC_W-1:0] MAX24 = ACC_W'(8388607);
	localparam logic signed [ACC_W-1:0] MIN24 = -ACC_W'(8388608);
	localparam logic signed [SUM_W:0]   MAX40 = {2'b00, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W:0]   MIN40 = {2'b11, {(SUM_W-1){1'b0}}};

	// configuration
	logic [GAIN_W-1:0]        wprev_q, wcur_q, tdiv_q;
	logic signed [GAIN_W-1:0] gp_q, gi_q, gd_q;
	logic [BAND_W-1:0]        band_q;

	// controller state
	logic signed [ERR_W-1:0]  f_q, last_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]         cnt_q;

	// work registers
	logic [3:0]               state_q;
	logic signed [ANGLE_W-1:0] raw_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ERR_W:0]    diff_q;
	logic [GAIN_W-1:0]        rem_q;
	logic [DIV_STEPS-1:0]     work_q;
	logic [STEP_W-1:0]        step_q;
	logic                     neg_q, ovf_q;

	logic                     out_valid_q, settled_q;
	logic signed [DRIVE_W-1:0] drive_q;

	// combinational
	logic                     accept;
	logic signed [ANGLE_W+1:0] diff_in, raw_in;
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [ACC_W-1:0]  prod_ext, f_shift;
	logic signed [ERR_W-1:0]  f_new;
	logic signed [SUM_W:0]    sum_wide;
	logic signed [SUM_W-1:0]  sum_new;
	logic signed [ERR_W:0]    f_abs;
	logic                     in_band;
	logic [GAIN_W-1:0]        div_eff;
	logic [ACC_W-1:0]         acc_abs;
	logic [DVD_W-1:0]         dvd;
	logic [GAIN_W:0]          trial, trial_sub;
	logic                     q_bit;
	logic                     out_free;
	logic signed [DRIVE_W-1:0] drive_new;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// wrap target minus measured into (-HALF_TURN, HALF_TURN]
	always_comb begin
		diff_in = $signed({2'b00, heading_goal}) - $signed({2'b00, heading_now});
		if (diff_in > (ANGLE_W+2)'(HALF_TURN))
			raw_in = diff_in - (ANGLE_W+2)'(FULL_TURN);
		else if (diff_in <= -(ANGLE_W+2)'(HALF_TURN))
			raw_in = diff_in + (ANGLE_W+2)'(FULL_TURN);
		else
			raw_in = diff_in;
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_W0: begin
				mul_a = $signed({1'b0, wprev_q});
				mul_b = MB_W'(f_q);
			end
			S_W1: begin
				mul_a = $signed({1'b0, wcur_q});
				mul_b = MB_W'(raw_q);
			end
			S_SUM: begin
				mul_a = MA_W'(gp_q);
				mul_b = MB_W'(f_q);
			end
			S_PD: begin
				mul_a = MA_W'(gd_q);
				mul_b = diff_q;
			end
			S_IL: begin
				mul_a = MA_W'(gi_q);
				mul_b = $signed({1'b0, sum_q[ERR_W-1:0]});
			end
			S_IH: begin
				// upper part of the integral carries the sign
				mul_a = MA_W'(gi_q);
				mul_b = MB_W'($signed(sum_q[SUM_W-1:ERR_W]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_ext = ACC_W'(prod_q);

	// filter result, floor shift then saturation
	always_comb begin
		f_shift = acc_q >>> 15;
		if (f_shift > MAX24)
			f_new = ERR_W'(MAX24);
		else if (f_shift < MIN24)
			f_new = ERR_W'(MIN24);
		else
			f_new = f_shift[ERR_W-1:0];
	end

	always_comb begin
		sum_wide = (SUM_W+1)'(sum_q) + (SUM_W+1)'(f_q);
		if (sum_wide > MAX40)
			sum_new = MAX40[SUM_W-1:0];
		else if (sum_wide < MIN40)
			sum_new = MIN40[SUM_W-1:0];
		else
			sum_new = sum_wide[SUM_W-1:0];
	end

	assign f_abs   = f_q[ERR_W-1] ? -(ERR_W+1)'(f_q) : (ERR_W+1)'(f_q);
	assign in_band = f_abs < $signed({{(ERR_W+1-BAND_W){1'b0}}, band_q});

	assign div_eff = (tdiv_q == '0) ? GAIN_W'(1) : tdiv_q;
	assign acc_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign dvd     = {acc_abs, 2'b00};

	assign trial     = {rem_q, work_q[DIV_STEPS-1]};
	assign trial_sub = trial - {1'b0, div_eff};
	assign q_bit     = (trial >= {1'b0, div_eff});

	// quotient magnitude to signed drive, saturated
	always_comb begin
		if (neg_q) begin
			if (ovf_q || (work_q > DIV_STEPS'(8388608)))
				drive_new = DRIVE_W'(MIN24);
			else
				drive_new = -$signed(work_q);
		end else begin
			if (ovf_q || work_q[DIV_STEPS-1])
				drive_new = DRIVE_W'(MAX24);
			else
				drive_new = $signed(work_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wprev_q <= GAIN_W'(16384);
			wcur_q  <= GAIN_W'(16384);
			gp_q    <= GAIN_W'(256);
			gi_q    <= '0;
			gd_q    <= '0;
			band_q  <= BAND_W'(64);
			tdiv_q  <= GAIN_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WEIGHT_PREV: wprev_q <= cfg_data;
				CFG_WEIGHT_CUR:  wcur_q  <= cfg_data;
				CFG_GAIN_P:      gp_q    <= $signed(cfg_data);
				CFG_GAIN_I:      gi_q    <= $signed(cfg_data);
				CFG_GAIN_D:      gd_q    <= $signed(cfg_data);
				CFG_SETTLE_BAND: band_q  <= cfg_data[BAND_W-1:0];
				CFG_TURN_DIV:    tdiv_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			f_q         <= '0;
			last_q      <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (restart) begin
							f_q    <= '0;
							last_q <= '0;
							sum_q  <= '0;
							cnt_q  <= '0;
						end
						state_q <= S_W0;
					end
				end
				S_W0:   state_q <= S_W1;
				S_W1:   state_q <= S_W2;
				S_W2:   state_q <= S_F;
				S_F: begin
					f_q     <= f_new;
					state_q <= S_SUM;
				end
				S_SUM: begin
					sum_q <= sum_new;
					if (in_band) begin
						if (cnt_q != '1)
							cnt_q <= cnt_q + 1'b1;
					end else begin
						cnt_q <= '0;
					end
					state_q <= S_PD;
				end
				S_PD: begin
					last_q  <= f_q;
					state_q <= S_IL;
				end
				S_IL:   state_q <= S_IH;
				S_IH:   state_q <= S_AH;
				S_AH:   state_q <= S_DIV0;
				S_DIV0: state_q <= S_DIV;
				S_DIV: begin
					if (step_q == '0)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				if (accept)
					raw_q <= raw_in[ANGLE_W-1:0];
			end
			S_W1:  acc_q <= prod_ext;
			S_W2:  acc_q <= acc_q + prod_ext + ROUND_15;
			S_SUM: diff_q <= (ERR_W+1)'(f_q) - (ERR_W+1)'(last_q);
			S_PD:  acc_q <= prod_ext;
			S_IL:  acc_q <= acc_q + prod_ext;
			S_IH:  acc_q <= acc_q + prod_ext;
			S_AH:  acc_q <= acc_q + (prod_ext <<< ERR_W);
			S_DIV0: begin
				// result is negative when the PID sum is positive
				neg_q  <= !acc_q[ACC_W-1] && (acc_q != '0);
				ovf_q  <= (dvd[DVD_W-1:DIV_STEPS] >= (DVD_W-DIV_STEPS)'(div_eff));
				rem_q  <= dvd[DIV_STEPS+GAIN_W-1:DIV_STEPS];
				work_q <= dvd[DIV_STEPS-1:0];
				step_q <= STEP_W'(DIV_STEPS-1);
			end
			S_DIV: begin
				rem_q  <= q_bit ? trial_sub[GAIN_W-1:0] : trial[GAIN_W-1:0];
				work_q <= {work_q[DIV_STEPS-2:0], q_bit};
				step_q <= step_q - 1'b1;
			end
			S_FIN: begin
				if (out_free) begin
					drive_q   <= drive_new;
					settled_q <= (cnt_q >= CNT_W'(SETTLE_FRAMES));
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign turn_drive = drive_q;
	assign settled    = settled_q;

endmodule

`default_nettype wire

### rtl/hpsd_checker.sv
// Port-level checks for the heading PID block, bound to its top level.
// Uses hpsd_pkg for port widths.
`default_nettype none

module hpsd_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire hpsd_pkg::cfg_idx_t               cfg_index,
	input  wire logic [hpsd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	input  wire logic                             in_stall,
	input  wire logic [hpsd_pkg::ANGLE_W-1:0]     heading_now,
	input  wire logic [hpsd_pkg::ANGLE_W-1:0]     heading_goal,
	input  wire logic                             restart,
	input  wire logic                             out_valid,
	input  wire logic                             out_stall,
	input  wire logic signed [hpsd_pkg::DRIVE_W-1:0] turn_drive,
	input  wire logic                             settled
);
	import hpsd_pkg::*;

	logic in_acc;

	assign in_acc = in_valid && !in_stall;

	// an item in work blocks the input channel
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input not stalled after an item was taken");

	// a new result only appears at the end of work on an item
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no item in work");

	// no result rises straight after an item is taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result came too soon after an item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(turn_drive) && $stable(settled))
		else $error("stalled result changed");

endmodule

bind heading_pid_with_settle_detect hpsd_checker u_hpsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_we       (cfg_we),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.heading_now  (heading_now),
	.heading_goal (heading_goal),
	.restart      (restart),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.turn_drive   (turn_drive),
	.settled      (settled)
);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for heading_pid_with_settle_detect.
// Drives heading items and register writes and checks every result against a predictor.
// Depends on hpsd_pkg and the block's RTL only.

module tb_top;
	import hpsd_pkg::*;

	localparam int        DRAIN_CYCLES    = 40;   // longer than the block's latency
	localparam int        STALL_LIMIT     = 2000;
	localparam int        RAND_PHASES     = 12;
	localparam int        ITEMS_PER_PHASE = 85;
	localparam int        QUIET_PHASE     = 5;
	localparam int        PAUSE_PHASE     = 3;
	localparam cfg_idx_t  CFG_UNUSED      = 3'd7;
	localparam longint    MAX24 = 64'sd8388607;
	localparam longint    MIN24 = -64'sd8388608;
	localparam longint    MAX40 = 64'sd549755813887;
	localparam longint    MIN40 = -64'sd549755813888;

	typedef struct {
		logic signed [DRIVE_W-1:0] drive;
		logic                      settled;
	} steer_t;

	class heading_scoreboard;
		logic [15:0]        w_prev, w_cur, divisor;
		logic signed [15:0] kp, ki, kd;
		logic [BAND_W-1:0]  band;
		longint             filt, integ, last_filt;
		int unsigned        settle_run;
		steer_t             steer_due[$];
		int                 errors, items, checked, settled_seen, restarts;

		function new();
			w_prev = 16'd16384;
			w_cur = 16'd16384;
			kp = 16'sd256;
			ki = 16'sd0;
			kd = 16'sd0;
			band = 14'd64;
			divisor = 16'd256;
			clear_state();
			errors = 0;
			items = 0;
			checked = 0;
			settled_seen = 0;
			restarts = 0;
		endfunction

		function void clear_state();
			filt = 0;
			integ = 0;
			last_filt = 0;
			settle_run = 0;
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function int pending();
			return steer_due.size();
		endfunction

		function void note_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_WEIGHT_PREV: w_prev = data;
				CFG_WEIGHT_CUR:  w_cur = data;
				CFG_GAIN_P:      kp = data;
				CFG_GAIN_I:      ki = data;
				CFG_GAIN_D:      kd = data;
				CFG_SETTLE_BAND: band = data[BAND_W-1:0];
				CFG_TURN_DIV:    divisor = data;
				default: ;
			endcase
		endfunction

		// predict the steering result of one accepted heading item
		function void take_heading(logic [ANGLE_W-1:0] now_v, logic [ANGLE_W-1:0] goal_v,
			logic rst_v);
			longint raw, acc, pid, quot, div, mag;
			steer_t s;
			items++;
			if (rst_v) begin
				clear_state();
				restarts++;
			end
			raw = longint'(goal_v) - longint'(now_v);
			while (raw <= -HALF_TURN)
				raw += FULL_TURN;
			while (raw > HALF_TURN)
				raw -= FULL_TURN;
			acc = longint'(w_prev) * filt + longint'(w_cur) * raw + 16384;
			filt = clamp(acc >>> 15, MIN24, MAX24);
			integ = clamp(integ + filt, MIN40, MAX40);
			pid = longint'(kp) * filt + longint'(ki) * integ + longint'(kd) * (filt - last_filt);
			last_filt = filt;
			mag = filt < 0 ? -filt : filt;
			if (mag < longint'(band)) begin
				if (settle_run < 65535)
					settle_run++;
			end else begin
				settle_run = 0;
			end
			div = (divisor == 16'd0) ? 1 : longint'(divisor);
			quot = clamp((-pid * 4) / div, MIN24, MAX24);
			s.drive = quot[DRIVE_W-1:0];
			s.settled = settle_run >= SETTLE_FRAMES;
			steer_due.push_back(s);
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("%0t ns mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic signed [DRIVE_W-1:0] drive, logic st);
			steer_t e;
			if (steer_due.size() == 0) begin
				report($sformatf("result drive %0d settled %0b with nothing expected", drive, st));
				return;
			end
			e = steer_due.pop_front();
			checked++;
			if (st)
				settled_seen++;
			if (drive !== e.drive)
				report($sformatf("item %0d turn_drive exp %0d got %0d", checked, e.drive, drive));
			if (st !== e.settled)
				report($sformatf("item %0d settled exp %0b got %0b", checked, e.settled, st));
		endtask
	endclass

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	cfg_idx_t                    cfg_index = CFG_WEIGHT_PREV;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [ANGLE_W-1:0]          heading_now = '0;
	logic [ANGLE_W-1:0]          heading_goal = '0;
	logic                        restart = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [DRIVE_W-1:0]   turn_drive;
	logic                        settled;

	logic                        idle_on = 1'b1;
	heading_scoreboard           sb = new();

	heading_pid_with_settle_detect dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.heading_now(heading_now),
		.heading_goal(heading_goal),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.turn_drive(turn_drive),
		.settled(settled)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// monitor: sample handshakes at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.note_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				sb.take_heading(heading_now, heading_goal, restart);
			if (out_valid && !out_stall)
				sb.check_result(turn_drive, settled);
		end
	end

	always @(posedge clk)
		out_stall <= idle_on && ($urandom_range(99) < 32);

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: %0d cycles without a handshake", STALL_LIMIT);
		$display("tb_top: errors");
		$finish;
	end

	task automatic send_item(input logic [ANGLE_W-1:0] now_v, input logic [ANGLE_W-1:0] goal_v,
		input logic rst_v);
		while (idle_on && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		heading_now <= now_v;
		heading_goal <= goal_v;
		restart <= rst_v;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending and wait for every outstanding result, then let the pipeline settle
	task automatic drain_block();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom);
			default: return 16'($urandom_range(2048) - 1024);
		endcase
	endfunction

	initial begin : main
		int k, ph, r, spread, delta, aim, settings;
		logic [15:0] wp, wc, band_d, div_d;
		logic [ANGLE_W-1:0] now_v, goal_v;
		logic rst_v;

		settings = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// wrap boundaries and out-of-range headings under reset settings
		send_item(ANGLE_W'(0), ANGLE_W'(0), 1'b1);
		send_item(ANGLE_W'(0), ANGLE_W'(HALF_TURN), 1'b0);
		send_item(ANGLE_W'(HALF_TURN), ANGLE_W'(0), 1'b0);
		send_item(ANGLE_W'(0), ANGLE_W'(FULL_TURN - 1), 1'b0);
		send_item(15'h7FFF, ANGLE_W'(0), 1'b0);
		send_item(ANGLE_W'(0), 15'h7FFF, 1'b0);
		// on target long enough to raise settled
		for (k = 0; k < 11; k++)
			send_item(ANGLE_W'(1000), ANGLE_W'(1000), k == 0);

		// weights above one, zero divisor, extreme gains, band with upper bits set
		drain_block();
		write_reg(CFG_WEIGHT_PREV, 16'hFFFF);
		write_reg(CFG_WEIGHT_CUR, 16'hFFFF);
		write_reg(CFG_GAIN_P, 16'h7FFF);
		write_reg(CFG_GAIN_I, 16'h8000);
		write_reg(CFG_GAIN_D, 16'h7FFF);
		write_reg(CFG_SETTLE_BAND, 16'hFFFF);
		write_reg(CFG_TURN_DIV, 16'd0);
		write_reg(CFG_UNUSED, 16'hFFFF);
		settings++;
		for (k = 0; k < 7; k++)
			send_item(ANGLE_W'(0), ANGLE_W'(HALF_TURN), k == 0);

		// opposite extremes
		drain_block();
		write_reg(CFG_WEIGHT_PREV, 16'd0);
		write_reg(CFG_WEIGHT_CUR, 16'h8000);
		write_reg(CFG_GAIN_P, 16'h8000);
		write_reg(CFG_GAIN_I, 16'h7FFF);
		write_reg(CFG_GAIN_D, 16'h8000);
		write_reg(CFG_SETTLE_BAND, 16'd0);
		write_reg(CFG_TURN_DIV, 16'd1);
		settings++;
		send_item(ANGLE_W'(FULL_TURN - 1), ANGLE_W'(0), 1'b1);
		send_item(ANGLE_W'(0), ANGLE_W'(HALF_TURN), 1'b0);
		send_item(ANGLE_W'(5000), ANGLE_W'(5000), 1'b0);

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			drain_block();
			idle_on = (ph != QUIET_PHASE);
			case ($urandom_range(5))
				0: begin wp = 16'd0; wc = 16'h8000; end
				1: begin wp = 16'h8000; wc = 16'($urandom_range(32768)); end
				2: begin wp = 16'($urandom); wc = 16'($urandom); end
				default: begin
					wp = 16'($urandom_range(32767));
					wc = 16'h8000 - wp;
				end
			endcase
			case ($urandom_range(5))
				0: band_d = 16'd0;
				1: band_d = 16'(HALF_TURN);
				2: band_d = 16'hFFFF;
				default: band_d = 16'($urandom_range(600));
			endcase
			case ($urandom_range(5))
				0: div_d = 16'd0;
				1: div_d = 16'd1;
				2: div_d = 16'hFFFF;
				default: div_d = 16'($urandom_range(4096, 1));
			endcase
			write_reg(CFG_WEIGHT_PREV, wp);
			write_reg(CFG_WEIGHT_CUR, wc);
			write_reg(CFG_GAIN_P, pick_gain());
			write_reg(CFG_GAIN_I, pick_gain());
			write_reg(CFG_GAIN_D, pick_gain());
			write_reg(CFG_SETTLE_BAND, band_d);
			write_reg(CFG_TURN_DIV, div_d);
			write_reg(CFG_UNUSED, 16'($urandom));
			settings++;

			aim = $urandom_range(FULL_TURN - 1);
			spread = $urandom_range(3000);
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (ph == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2)
					drain_block();
				rst_v = (k == 0) || ($urandom_range(99) < 4);
				r = $urandom_range(99);
				if (r < 60) begin
					// track a held goal with a shrinking offset so the settle count builds
					if ($urandom_range(29) == 0) begin
						aim = $urandom_range(FULL_TURN - 1);
						spread = $urandom_range(3000);
					end
					delta = int'($urandom_range(2 * spread)) - spread;
					spread = spread - spread / 8;
					now_v = 15'((aim + delta + FULL_TURN) % FULL_TURN);
					goal_v = 15'(aim);
				end else if (r < 85) begin
					now_v = 15'($urandom_range(FULL_TURN - 1));
					goal_v = 15'($urandom_range(FULL_TURN - 1));
				end else begin
					now_v = 15'($urandom);
					goal_v = 15'($urandom);
				end
				send_item(now_v, goal_v, rst_v);
			end
		end

		idle_on = 1'b1;
		drain_block();
		$display("covered %0d items (%0d with restart) over %0d register settings",
			sb.items, sb.restarts, settings);
		$display("checked %0d results, settled flag high on %0d", sb.checked, sb.settled_seen);
		if (sb.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
